@@ rtl/rit_pkg.sv @@
package rit_pkg;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [63:0] guid_high;
    logic [63:0] guid_low;
  } guid_t;

  typedef struct packed {
    cmd_t        command;
    logic        table_index;
    logic [63:0] guid_high;
    logic [63:0] guid_low;
  } in_word_t;

  typedef struct packed {
    logic hit;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

@@ rtl/rit_stream_if.sv @@
interface rit_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rit_mem.sv @@
module rit_mem
  import rit_pkg::*;
#(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  guid_t         wdata,
  input  logic [AW-1:0] raddr,
  output guid_t         rdata
);

  localparam int DEPTH = 1 << AW;

  guid_t mem [DEPTH];
  guid_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rit_ctrl.sv @@
module rit_ctrl
  import rit_pkg::*;
#(
  parameter int TABLES  = 2,
  parameter int ENTRIES = 256,
  parameter int TW      = 1,
  parameter int KW      = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  rit_stream_if.sink          in_ch,
  rit_stream_if.source        out_ch,
  output logic                mem_we,
  output logic [TW+KW-1:0]    mem_waddr,
  output guid_t               mem_wdata,
  output logic [TW+KW-1:0]    mem_raddr,
  input  guid_t               mem_rdata
);

  localparam int AW            = TW + KW;
  localparam int PTRS          = 1 << TW;
  localparam logic [KW-1:0] LAST_SLOT = KW'(ENTRIES - 1);
  localparam logic [AW-1:0] LAST_ADDR = {AW{1'b1}};

  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_r;
  logic [KW-1:0]  slot_r;
  in_word_t       item_r;
  logic           hit_r;
  logic           cmp_en_r;
  logic [KW-1:0]  ptr_r [PTRS];
  logic           out_valid_r;
  logic           out_hit_r;

  logic           in_fire;
  logic           out_free;
  logic           in_range;
  logic [TW-1:0]  tbl;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_range = 32'(in_ch.data.table_index) < TABLES;
  assign tbl      = TW'(item_r.table_index);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = in_range ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        if (slot_r == LAST_SLOT) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = (item_r.command == CMD_ADD) ? ST_WRITE : ST_RESP;
      end
      ST_WRITE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_r;
    mem_wdata   = '{guid_high: {32'(clr_r[KW-1:0]), 32'b0}, guid_low: 64'b0};
    mem_raddr   = {tbl, slot_r};
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {tbl, ptr_r[tbl]};
        mem_wdata = '{guid_high: item_r.guid_high, guid_low: item_r.guid_low};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      slot_r      <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PTRS; i++) begin
        ptr_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cmp_en_r <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (in_fire) begin
        slot_r <= '0;
      end else if (state_r == ST_SCAN) begin
        slot_r <= slot_r + 1'b1;
      end
      // advance the oldest pointer, wrap after the last slot
      if (state_r == ST_WRITE) begin
        ptr_r[tbl] <= (ptr_r[tbl] == LAST_SLOT) ? '0 : ptr_r[tbl] + 1'b1;
      end
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_ch.data;
      hit_r  <= 1'b0;
    end else if (cmp_en_r && mem_rdata.guid_high == item_r.guid_high
                 && mem_rdata.guid_low == item_r.guid_low) begin
      hit_r <= 1'b1;
    end
    if (state_r == ST_RESP && out_free) begin
      out_hit_r <= hit_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data.hit = out_hit_r;

endmodule

@@ rtl/recent_id_route_table_core.sv @@
// Recent identifier route table.
// in_ch carries one word per command: add or look up a 128-bit identifier
// in one of TABLES tables. out_ch returns one word per command: hit is set
// when the identifier was in the table before the command took effect.
// Add overwrites the table's oldest slot and advances its pointer.
// The single compare unit walks the slots of the table through one read
// port of the slot memory, one slot per cycle; an add then writes its slot.
// The next word is taken only after the result is loaded into the output
// register. A table index at or above TABLES returns hit low, no change.
// Reset: a clearing pass over all 2**(max(1,clog2(TABLES))+clog2(ENTRIES))
// slots (512 by default) loads slot i of every table with i in the top 32
// bits; in_ch.ready stays low until it ends.
// Stall: the result waits in an output register; while it is not taken
// the next item can still be accepted and searched, and its result holds
// until the register frees.
module recent_id_route_table_core
  import rit_pkg::*;
#(
  parameter int TABLES  = 2,
  parameter int ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  rit_stream_if.sink   in_ch,
  rit_stream_if.source out_ch
);

  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int KW = $clog2(ENTRIES);
  localparam int AW = TW + KW;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  guid_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  guid_t         mem_rdata;

  rit_ctrl #(
    .TABLES  (TABLES),
    .ENTRIES (ENTRIES),
    .TW      (TW),
    .KW      (KW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rit_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ dv/tb_recent_id_route_table_core.sv @@
`timescale 1ns / 1ps

module tb_recent_id_route_table_core;
  import rit_pkg::*;

  localparam int TABLES          = 2;
  localparam int ENTRIES         = 256;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int LIMIT_CYCLES    = 2_000_000;

  typedef struct {
    in_word_t word;
    logic     hit;
  } hit_expect_t;

  logic clk = 1'b0;
  logic rst_n;

  rit_stream_if #(.word_t(in_word_t))  in_ch ();
  rit_stream_if #(.word_t(out_word_t)) out_ch ();

  recent_id_route_table_core #(
    .TABLES (TABLES),
    .ENTRIES(ENTRIES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the route tables
  logic [63:0] shadow_high [TABLES][ENTRIES];
  logic [63:0] shadow_low  [TABLES][ENTRIES];
  int unsigned oldest_slot [TABLES];

  hit_expect_t pending_hits [$];
  guid_t       seen_ids [$];

  int  burst_left    = 1;
  bit  steady_offer  = 1'b0;
  bit  hold_off_req  = 1'b0;
  int  fault_count   = 0;
  int  add_count     = 0;
  int  lookup_count  = 0;
  int  hit_count     = 0;
  int  wrap_count    = 0;
  int  result_count  = 0;

  function automatic guid_t reset_guid(input int unsigned slot);
    return {slot[31:0], 32'h0, 64'h0};
  endfunction

  // Presence before the word, then apply an add
  function automatic logic route_step(input in_word_t w);
    logic found;
    int   t;
    found = 1'b0;
    t = int'(w.table_index);
    if (t < TABLES) begin
      for (int k = 0; k < ENTRIES; k++)
        if (shadow_high[t][k] == w.guid_high && shadow_low[t][k] == w.guid_low)
          found = 1'b1;
      if (w.command == CMD_ADD) begin
        shadow_high[t][oldest_slot[t]] = w.guid_high;
        shadow_low[t][oldest_slot[t]]  = w.guid_low;
        if (oldest_slot[t] == ENTRIES - 1) begin
          oldest_slot[t] = 0;
          wrap_count++;
        end else begin
          oldest_slot[t]++;
        end
      end
    end
    return found;
  endfunction

  function automatic guid_t pick_guid();
    guid_t g;
    int    r;
    int    b;
    r = $urandom_range(99);
    if (r < 30 || seen_ids.size() == 0) begin
      g = {$urandom, $urandom, $urandom, $urandom};
    end else if (r < 65) begin
      g = seen_ids[$urandom_range(seen_ids.size() - 1)];
    end else if (r < 80) begin
      g = reset_guid($urandom_range(300));
    end else if (r < 88) begin
      // near miss: one bit off a known identifier
      g = seen_ids[$urandom_range(seen_ids.size() - 1)];
      b = $urandom_range(127);
      g[b] = ~g[b];
    end else if (r < 94) begin
      g = ($urandom_range(1) != 0) ? '1 : '0;
    end else begin
      g = seen_ids[$urandom_range(seen_ids.size() - 1)];
      g.guid_low = {$urandom, $urandom};
    end
    return g;
  endfunction

  task automatic send_word(input cmd_t cmd, input logic tbl, input guid_t id);
    in_word_t    w;
    hit_expect_t e;
    int          gap;
    int          r;
    w.command     = cmd;
    w.table_index = tbl;
    w.guid_high   = id.guid_high;
    w.guid_low    = id.guid_low;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    e.word = w;
    e.hit  = route_step(w);
    pending_hits.push_back(e);
    if (cmd == CMD_ADD) begin
      add_count++;
      seen_ids.push_back(id);
      if (seen_ids.size() > 600) void'(seen_ids.pop_front());
    end else begin
      lookup_count++;
    end
    if (e.hit) hit_count++;
    if (!steady_offer) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(8, 1);
        r = $urandom_range(9);
        gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(6, 1) : $urandom_range(300, 1);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic run_random(input int count, input int add_pct, input int tbl1_pct);
    cmd_t cmd;
    logic tbl;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_LOOKUP;
      tbl = ($urandom_range(99) < tbl1_pct);
      send_word(cmd, tbl, pick_guid());
    end
  endtask

  task automatic test_reset_contents();
    send_word(CMD_LOOKUP, 1'b0, reset_guid(0));
    send_word(CMD_LOOKUP, 1'b1, reset_guid(ENTRIES - 1));
    send_word(CMD_LOOKUP, 1'b0, reset_guid(ENTRIES));
    send_word(CMD_LOOKUP, 1'b1, {64'h0000_0001_0000_0000, 64'h1});
    send_word(CMD_LOOKUP, 1'b0, '1);
  endtask

  task automatic test_add_lookup();
    guid_t id;
    id = {$urandom, $urandom, $urandom, $urandom};
    // first add evicts slot 0 of table 0
    send_word(CMD_ADD,    1'b0, '1);
    send_word(CMD_LOOKUP, 1'b0, '1);
    send_word(CMD_LOOKUP, 1'b1, '1);
    send_word(CMD_LOOKUP, 1'b0, reset_guid(0));
    send_word(CMD_ADD,    1'b1, id);
    send_word(CMD_LOOKUP, 1'b1, id);
    send_word(CMD_ADD,    1'b1, {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
    send_word(CMD_LOOKUP, 1'b1, {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
  endtask

  task automatic test_duplicate_add();
    guid_t id;
    id = {$urandom, $urandom, $urandom, $urandom};
    send_word(CMD_ADD,    1'b0, id);
    send_word(CMD_ADD,    1'b0, id);
    send_word(CMD_LOOKUP, 1'b0, id);
    send_word(CMD_ADD,    1'b1, reset_guid(7));
    send_word(CMD_LOOKUP, 1'b1, reset_guid(7));
  endtask

  // Mostly adds to table 1 to advance its write pointer
  task automatic test_fifo_wrap();
    run_random(320, 85, 90);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    steady_offer = 1'b1;
    for (int n = 0; n < 8; n++)
      send_word(($urandom_range(1) != 0) ? CMD_ADD : CMD_LOOKUP, 1'($urandom_range(1)),
                pick_guid());
    steady_offer = 1'b0;
  endtask

  task automatic test_random_mix();
    run_random(340, 55, 30);
  endtask

  // Result receiver: ready pattern plus one long hold-off on request
  initial begin : result_sink
    int span;
    int mode;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(9);
        span = (mode < 4) ? $urandom_range(200, 1) :
               (mode < 7) ? $urandom_range(60, 1) : $urandom_range(300, 1);
        for (int k = 0; k < span; k++) begin
          if (mode < 4)
            out_ch.ready <= 1'b1;
          else if (mode < 7)
            out_ch.ready <= 1'($urandom_range(1));
          else
            out_ch.ready <= (k == span - 1);
          @(posedge clk);
          if (hold_off_req) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_hits.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] result hit=%0b with no command outstanding", $time,
                   out_ch.data.hit);
      end else begin
        hit_expect_t e;
        e = pending_hits.pop_front();
        if (out_ch.data.hit !== e.hit) begin
          fault_count++;
          if (fault_count <= 10)
            $display("[%0t] %s table %0d id %h_%h: hit expected %0b, got %0b", $time,
                     e.word.command.name(), e.word.table_index, e.word.guid_high,
                     e.word.guid_low, e.hit, out_ch.data.hit);
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timeout with %0d results outstanding", pending_hits.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    for (int t = 0; t < TABLES; t++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_high[t][i] = {i[31:0], 32'h0};
        shadow_low[t][i]  = 64'h0;
      end
      oldest_slot[t] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_add_lookup();
    test_duplicate_add();
    test_fifo_wrap();
    test_backpressure();
    test_random_mix();

    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Ran %0d commands: %0d adds, %0d lookups, %0d expected hits",
             add_count + lookup_count, add_count, lookup_count, hit_count);
    $display("Checked %0d results, %0d table pointer wraps, %0d errors",
             result_count, wrap_count, fault_count);
    if (fault_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rit_pkg.sv
rtl/rit_stream_if.sv
rtl/rit_mem.sv
rtl/rit_ctrl.sv
rtl/recent_id_route_table_core.sv
dv/tb_recent_id_route_table_core.sv
